// File: src/ipm_pkg.sv
package ipm_pkg;

  localparam int unsigned MaxFramePixels = 4194304;
  localparam int unsigned CountCap       = 8388607;
  localparam int unsigned FrameLimitInt  =
    (MaxFramePixels < CountCap) ? MaxFramePixels : CountCap;

  localparam int AccW   = 40;
  localparam int CntW   = 23;
  localparam int PsnrW  = 16;
  localparam int FracW  = 24;
  localparam int ExpW   = 6;
  localparam int LogW   = ExpW + FracW;
  localparam int MantW  = 32;
  localparam int IterW  = 5;
  localparam int ScaleW = 26;
  localparam int ProdW  = LogW + ScaleW;

  localparam logic [CntW-1:0]   FrameLimit = CntW'(FrameLimitInt);
  localparam logic [15:0]       PeakSq     = 16'd65025;
  localparam logic [ScaleW-1:0] TenLog2Q16 = 26'd50504453;
  localparam logic [ExpW-1:0]   ExpTop     = 6'd39;
  localparam logic [IterW-1:0]  IterLast   = 5'd23;

  localparam logic signed [PsnrW-1:0] PsnrMax = 16'sh7FFF;
  localparam logic signed [PsnrW-1:0] PsnrMin = -16'sh8000;

  typedef struct packed {
    logic acc_en;
    logic snap;
    logic mul_n;
    logic load;
    logic load_sel;
    logic norm_step;
    logic iter_start;
    logic iter_step;
    logic store_n;
    logic store_s;
    logic scale;
    logic round;
    logic out_load;
  } ipm_cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic norm_done;
    logic iter_done;
    logic out_full;
  } ipm_stat_t;

endpackage

// File: src/ipm_ifs.sv
interface ipm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] orig_red;
  logic [7:0] orig_green;
  logic [7:0] orig_blue;
  logic [7:0] comp_red;
  logic [7:0] comp_green;
  logic [7:0] comp_blue;
  logic       last_pixel;

  modport source(output valid, orig_red, orig_green, orig_blue, comp_red, comp_green,
                 comp_blue, last_pixel, input ready);
  modport sink(input valid, orig_red, orig_green, orig_blue, comp_red, comp_green,
               comp_blue, last_pixel, output ready);
endinterface

interface ipm_res_if;
  logic               valid;
  logic               ready;
  logic [39:0]        sum_sq_error;
  logic [22:0]        frame_pixels;
  logic signed [15:0] psnr_db;
  logic               identical;

  modport source(output valid, sum_sq_error, frame_pixels, psnr_db, identical,
                 input ready);
  modport sink(input valid, sum_sq_error, frame_pixels, psnr_db, identical,
               output ready);
endinterface

// File: src/image_psnr_meter.sv
// channel | dir | transfer moves
// pix     | in  | one reference/compared RGB pixel pair, last_pixel ends the frame
// res     | out | sum_sq_error, frame_pixels, psnr_db (Q8.8), identical per frame
//
// Non-last pixels stream back to back.
// After the last pixel, pix.ready drops for the finish: per log2
// (one for N, one for the error sum) up to 39 normalizing shifts and 24 squaring
// steps on a shared 32x32 multiplier, then scale and round.
// A zero error skips the logs. Reset clears sums, state and res.valid.
// A result waits in the output register; the finish stalls only if it is not taken.
module image_psnr_meter (
  input logic       clk,
  input logic       rst,
  ipm_pix_if.sink   pix,
  ipm_res_if.source res
);
  import ipm_pkg::*;

  ipm_cmd_t  cmd;
  ipm_stat_t stat;

  ipm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix.valid),
    .in_last  (pix.last_pixel),
    .in_ready (pix.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ipm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .orig_red      (pix.orig_red),
    .orig_green    (pix.orig_green),
    .orig_blue     (pix.orig_blue),
    .comp_red      (pix.comp_red),
    .comp_green    (pix.comp_green),
    .comp_blue     (pix.comp_blue),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (res.ready),
    .out_valid     (res.valid),
    .out_sum       (res.sum_sq_error),
    .out_count     (res.frame_pixels),
    .out_psnr      (res.psnr_db),
    .out_identical (res.identical)
  );

  a_ident_psnr: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.identical |-> res.psnr_db == PsnrMax)
    else $error("identical frame without saturated psnr");

  a_ident_sum: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.identical == (res.sum_sq_error == '0)))
    else $error("identical flag disagrees with error sum");

  a_count: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.frame_pixels != '0)
    else $error("empty frame reported");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready && pix.last_pixel |=> !pix.ready)
    else $error("pixel taken during finish");
endmodule

// File: src/ipm_ctrl.sv
module ipm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  ipm_pkg::ipm_stat_t stat,
  output ipm_pkg::ipm_cmd_t  cmd
);
  import ipm_pkg::*;

  localparam logic [3:0] S_ACC   = 4'd0;
  localparam logic [3:0] S_MULN  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_ITER  = 4'd4;
  localparam logic [3:0] S_STORE = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_ROUND = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       phase;
  logic       phase_next;
  logic       xfer;

  assign in_ready = (state == S_ACC);
  assign xfer     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.load_sel = phase;
    unique case (state)
      S_ACC: begin
        cmd.acc_en = xfer;
        if (xfer && in_last) begin
          cmd.snap   = 1'b1;
          state_next = S_MULN;
        end
      end
      S_MULN: begin
        cmd.mul_n  = 1'b1;
        phase_next = 1'b0;
        state_next = stat.sum_zero ? S_DONE : S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (stat.norm_done) begin
          cmd.iter_start = 1'b1;
          state_next     = S_ITER;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_ITER: begin
        cmd.iter_step = 1'b1;
        if (stat.iter_done) state_next = S_STORE;
      end
      S_STORE: begin
        if (phase) begin
          cmd.store_s = 1'b1;
          state_next  = S_SCALE;
        end else begin
          cmd.store_n = 1'b1;
          phase_next  = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end
endmodule

// File: src/ipm_datapath.sv
module ipm_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         orig_red,
  input  logic [7:0]         orig_green,
  input  logic [7:0]         orig_blue,
  input  logic [7:0]         comp_red,
  input  logic [7:0]         comp_green,
  input  logic [7:0]         comp_blue,
  input  ipm_pkg::ipm_cmd_t  cmd,
  output ipm_pkg::ipm_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [39:0]        out_sum,
  output logic [22:0]        out_count,
  output logic signed [15:0] out_psnr,
  output logic               out_identical
);
  import ipm_pkg::*;

  logic [AccW-1:0]  acc;
  logic [CntW-1:0]  cnt;
  logic [AccW-1:0]  acc_next;
  logic [CntW-1:0]  cnt_next;
  logic [AccW-1:0]  sum_snap;
  logic [CntW-1:0]  cnt_snap;
  logic [AccW-1:0]  n_val;
  logic [AccW-1:0]  x;
  logic [ExpW-1:0]  e;
  logic [MantW-1:0] m;
  logic [FracW-1:0] frac;
  logic [IterW-1:0] iter;
  logic [LogW-1:0]  log_n;
  logic [LogW:0]    mag;
  logic             neg;
  logic [ProdW:0]   prod;
  logic signed [PsnrW-1:0] psnr;

  logic [7:0]       d_r, d_g, d_b;
  logic [17:0]      e_pix;
  logic [AccW:0]    acc_sum;
  logic [63:0]      msq;
  logic [32:0]      mt;
  logic signed [LogW+1:0] diff;
  logic [ProdW:0]   rnd;
  logic [16:0]      r;
  logic             val;

  assign d_r = (orig_red   >= comp_red)   ? orig_red   - comp_red   : comp_red   - orig_red;
  assign d_g = (orig_green >= comp_green) ? orig_green - comp_green : comp_green - orig_green;
  assign d_b = (orig_blue  >= comp_blue)  ? orig_blue  - comp_blue  : comp_blue  - orig_blue;
  assign e_pix = 18'(16'(d_r) * 16'(d_r)) + 18'(16'(d_g) * 16'(d_g))
               + 18'(16'(d_b) * 16'(d_b));

  assign acc_sum = {1'b0, acc} + (AccW+1)'(e_pix);

  always_comb begin
    acc_next = acc;
    cnt_next = cnt;
    if (cnt < FrameLimit) begin
      acc_next = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
      cnt_next = cnt + 1'b1;
    end
  end

  assign msq  = 64'(m) * 64'(m);
  assign mt   = msq[63:31];
  assign diff = (LogW+2)'(log_n) - (LogW+2)'({e, frac});
  assign rnd  = prod + (ProdW+1)'(64'h80_0000_0000);
  assign r    = rnd[56:40];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (cmd.snap) begin
      acc <= '0;
      cnt <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      sum_snap <= acc_next;
      cnt_snap <= cnt_next;
    end
    if (cmd.mul_n) n_val <= AccW'(PeakSq) * AccW'(cnt_snap);
    if (cmd.load) begin
      x <= cmd.load_sel ? sum_snap : n_val;
      e <= ExpTop;
    end else if (cmd.norm_step) begin
      x <= {x[AccW-2:0], 1'b0};
      e <= e - 1'b1;
    end
    if (cmd.iter_start) begin
      m    <= x[AccW-1:AccW-MantW];
      frac <= '0;
      iter <= '0;
    end else if (cmd.iter_step) begin
      m    <= mt[32] ? mt[32:1] : mt[31:0];
      frac <= {frac[FracW-2:0], mt[32]};
      iter <= iter + 1'b1;
    end
    if (cmd.store_n) log_n <= {e, frac};
    if (cmd.store_s) begin
      neg <= diff[LogW+1];
      mag <= diff[LogW+1] ? (LogW+1)'(-diff) : (LogW+1)'(diff);
    end
    if (cmd.scale) prod <= (ProdW+1)'(mag) * (ProdW+1)'(TenLog2Q16);
    if (cmd.round) begin
      if (neg) psnr <= (r > 17'd32768) ? PsnrMin : -$signed(16'(r));
      else     psnr <= (r > 17'd32767) ? PsnrMax : $signed(16'(r));
    end
    if (cmd.out_load) begin
      out_sum       <= sum_snap;
      out_count     <= cnt_snap;
      out_identical <= (sum_snap == '0);
      out_psnr      <= ((sum_snap == '0) || (cnt_snap == '0)) ? PsnrMax : psnr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) val <= 1'b0;
    else if (cmd.out_load) val <= 1'b1;
    else if (out_ready) val <= 1'b0;
  end

  assign out_valid      = val;
  assign stat.sum_zero  = (sum_snap == '0) || (cnt_snap == '0);
  assign stat.norm_done = x[AccW-1];
  assign stat.iter_done = (iter == IterLast);
  assign stat.out_full  = val && !out_ready;
endmodule

// File: dv/tb_psnr_checker.sv
module tb_psnr_checker (
  input logic clk,
  input logic rst,
  ipm_pix_if  pix,
  ipm_res_if  res,
  output int  n_fail,
  output int  n_pending,
  output int  n_frames,
  output int  n_identical
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [39:0]        sum_sq;
    logic [22:0]        pixels;
    logic signed [15:0] psnr;
    logic               same;
  } frame_result_t;

  frame_result_t frame_q[$];
  logic [39:0] err_acc;
  logic [22:0] pix_cnt;

  function automatic logic [63:0] log2_q24(logic [63:0] x);
    int unsigned e;
    logic [63:0] t, m, frac;
    e = 0;
    t = x;
    frac = 0;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (64'(e) << 24) | frac;
  endfunction

  function automatic logic signed [15:0] psnr_of(logic [63:0] s, logic [63:0] n);
    longint d;
    logic [63:0] mag, r;
    d = longint'(log2_q24(64'd65025 * n)) - longint'(log2_q24(s));
    mag = (d < 0) ? 64'(-d) : 64'(d);
    r = (mag * 64'd50504453 + (64'd1 << 39)) >> 40;
    if (d < 0) return (r > 32768) ? -16'sd32768 : -16'(r);
    return (r > 32767) ? 16'sd32767 : 16'(r);
  endfunction

  function automatic logic [63:0] sq(logic [7:0] a, logic [7:0] b);
    logic [63:0] d;
    d = (a >= b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  always @(posedge clk) begin
    logic [63:0] e, acc;
    frame_result_t x, got;
    if (rst) begin
      err_acc <= '0;
      pix_cnt <= '0;
      frame_q.delete();
      n_fail <= 0;
      n_frames <= 0;
      n_identical <= 0;
    end else begin
      if (pix.valid && pix.ready) begin
        e = sq(pix.orig_red, pix.comp_red) + sq(pix.orig_green, pix.comp_green)
          + sq(pix.orig_blue, pix.comp_blue);
        acc = 64'(err_acc);
        x.pixels = pix_cnt;
        if (pix_cnt < 23'(ipm_pkg::FrameLimitInt)) begin
          acc = acc + e;
          if (acc > 64'hFF_FFFF_FFFF) acc = 64'hFF_FFFF_FFFF;
          x.pixels = pix_cnt + 1;
        end
        if (pix.last_pixel) begin
          x.sum_sq = acc[39:0];
          x.same = (acc == 0);
          x.psnr = (x.same || x.pixels == 0) ? 16'sd32767 : psnr_of(acc, 64'(x.pixels));
          frame_q.push_back(x);
          err_acc <= '0;
          pix_cnt <= '0;
        end else begin
          err_acc <= acc[39:0];
          pix_cnt <= x.pixels;
        end
      end
      if (res.valid && res.ready) begin
        got = '{res.sum_sq_error, res.frame_pixels, res.psnr_db, res.identical};
        n_frames <= n_frames + 1;
        if (got.same) n_identical <= n_identical + 1;
        if (frame_q.size() == 0) begin
          n_fail <= n_fail + 1;
          if (n_fail < 10) $display("unexpected frame result sum=%0d", got.sum_sq);
        end else begin
          x = frame_q.pop_front();
          if (x.sum_sq !== got.sum_sq || x.pixels !== got.pixels ||
              x.psnr !== got.psnr || x.same !== got.same) begin
            n_fail <= n_fail + 1;
            if (n_fail < 10)
              $display("mismatch: exp sum=%0d px=%0d psnr=%0d id=%0b got sum=%0d px=%0d psnr=%0d id=%0b",
                       x.sum_sq, x.pixels, x.psnr, x.same,
                       got.sum_sq, got.pixels, got.psnr, got.same);
          end
        end
      end
    end
  end

  assign n_pending = frame_q.size();
endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  ipm_pix_if pix ();
  ipm_res_if res ();
  int n_fail, n_pending, n_frames, n_identical;
  int n_sent = 0;
  int idle_cycles = 0;
  bit hold_res = 0;
  bit timed_out = 0;

  image_psnr_meter i_dut (.clk(clk), .rst(rst), .pix(pix), .res(res));
  tb_psnr_checker i_chk (.clk(clk), .rst(rst), .pix(pix), .res(res), .n_fail(n_fail),
                         .n_pending(n_pending), .n_frames(n_frames),
                         .n_identical(n_identical));

  initial forever #5 clk = ~clk;

  initial begin
    pix.valid = 0;
    pix.orig_red = 0;
    pix.orig_green = 0;
    pix.orig_blue = 0;
    pix.comp_red = 0;
    pix.comp_green = 0;
    pix.comp_blue = 0;
    pix.last_pixel = 0;
    res.ready = 0;
  end

  task automatic send(logic [7:0] o_r, o_g, o_b, c_r, c_g, c_b, logic last);
    pix.valid <= 1;
    {pix.orig_red, pix.orig_green, pix.orig_blue} <= {o_r, o_g, o_b};
    {pix.comp_red, pix.comp_green, pix.comp_blue} <= {c_r, c_g, c_b};
    pix.last_pixel <= last;
    do @(posedge clk); while (!pix.ready);
    n_sent++;
  endtask

  task automatic gap();
    pix.valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic send_rand(int len_max, bit near);
    int len;
    logic [7:0] o[3], c[3];
    len = $urandom_range(1, len_max);
    for (int i = 0; i < len; i++) begin
      for (int k = 0; k < 3; k++) begin
        o[k] = 8'($urandom);
        c[k] = near ? 8'(o[k] + $urandom_range(0, 6) - 3) : 8'($urandom);
      end
      if (near && $urandom_range(0, 3) == 0) c = o;
      send(o[0], o[1], o[2], c[0], c[1], c[2], i == len - 1);
      if ($urandom_range(0, 3) == 0) gap();
    end
  endtask

  always @(posedge clk) begin
    if (rst || hold_res) res.ready <= 0;
    else if (($urandom_range(0, 7) == 0) && !(n_sent % 200 < 40)) res.ready <= 0;
    else res.ready <= ($urandom_range(0, 3) != 0) || (n_sent % 200 < 40);
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(0, 0, 0, 0, 0, 0, 1);
    send(255, 255, 255, 0, 0, 0, 1);
    send(0, 0, 0, 255, 255, 255, 0);
    send(255, 0, 255, 0, 255, 0, 1);
    send(10, 20, 30, 10, 20, 30, 0);
    send(10, 20, 30, 11, 20, 30, 1);
    send(128, 64, 32, 127, 65, 33, 1);
    send(1, 2, 4, 8, 16, 32, 0);
    gap();
    send(170, 85, 15, 85, 170, 240, 1);
    send(0, 128, 255, 0, 128, 255, 1);
    send(255, 255, 255, 254, 255, 255, 1);
    for (int i = 0; i < 6; i++) send(8'(i * 40), 8'(255 - i), 8'(i), 8'(i), 8'(i), 8'(i), i == 5);
    gap();
    while (n_sent < 1450) begin
      case ($urandom_range(0, 9))
        0: send_rand(3, 0);
        1: send_rand(1, 1);
        2: send(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 1'($urandom));
        default: send_rand(40, $urandom_range(0, 2) != 0);
      endcase
      if ($urandom_range(0, 2) == 0) gap();
      if (n_sent > 600 && n_sent < 700 && !hold_res) begin
        hold_res <= 1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_res <= 0;
          end
        join_none
      end
      if (n_sent > 1000 && n_sent < 1040) begin
        pix.valid <= 0;
        while (n_pending != 0) @(posedge clk);
      end
    end
    pix.valid <= 0;
    while (n_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d pixels in %0d frames, %0d of them identical",
             n_sent, n_frames, n_identical);
    if (n_fail == 0 && n_pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: files.f
src/ipm_pkg.sv
src/ipm_ifs.sv
src/ipm_ctrl.sv
src/ipm_datapath.sv
src/image_psnr_meter.sv
dv/tb_psnr_checker.sv
dv/tb_top.sv
